// File: rtl/resp_request_deframer_defines.svh
// Assertion macros shared by the request deframer modules.
// Expects the including module to have signals named clock and reset.
`ifndef RESP_REQUEST_DEFRAMER_DEFINES_SVH
`define RESP_REQUEST_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define RRD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define RRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/rrd_pkg.sv
// Types, constants and helpers for the request deframer.
// No dependencies; imported by every rrd_ module and the top level.
package rrd_pkg;

   // Character codes
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   // Widths and limits
   localparam int ACC_W      = 25;
   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
   localparam int LINE_LIMIT = 16777216;
   localparam int LEN_W      = $clog2(LINE_LIMIT + 2);
   localparam int ARGS_W     = 11;
   localparam int ARG_IDX_W  = 10;
   localparam logic [ARG_IDX_W-1:0] ARG_IDX_MAX = {ARG_IDX_W{1'b1}};

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 25;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ARGUMENTS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BULK_LENGTH = 2'd1;
   localparam logic [ARGS_W-1:0] MAX_ARGUMENTS_RESET   = 11'd1024;
   localparam logic [ACC_W-1:0]  MAX_BULK_LENGTH_RESET = 25'd16777216;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_ARG_END = 2'd1,
      KIND_CMD_END = 2'd2,
      KIND_STOP    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CAUSE_NONE         = 3'd0,
      CAUSE_BAD_COUNT    = 3'd1,
      CAUSE_NO_DOLLAR    = 3'd2,
      CAUSE_BAD_LENGTH   = 3'd3,
      CAUSE_NO_CRLF      = 3'd4,
      CAUSE_LINE_LONG    = 3'd5,
      CAUSE_EMPTY_INLINE = 3'd6
   } cause_type;

   typedef struct packed {
      kind_type               kind;
      logic [7:0]             value;
      logic [ARG_IDX_W-1:0]   arg_index;
      cause_type              cause;
   } result_type;

   // One queue entry: the one or two results caused by a single byte
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } entry_type;

   typedef struct packed {
      logic      empty;
      entry_type entry;
   } head_type;

   function automatic logic is_space(logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic result_type mk_result(kind_type k, logic [7:0] v,
                                            logic [ARG_IDX_W-1:0] idx, cause_type cs);
      result_type r;
      r.kind      = k;
      r.value     = v;
      r.arg_index = idx;
      r.cause     = cs;
      return r;
   endfunction

endpackage

// File: rtl/rrd_queue.sv
// Short result queue between the parser front and the emitter back.
// Depends on rrd_pkg and resp_request_deframer_defines.svh.
`include "resp_request_deframer_defines.svh"

module rrd_queue import rrd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output head_type  head
);

   entry_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.empty = (count_ff == '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   `RRD_ASSERT_IMPLY(a_no_overflow, push, !full, "result queue written while full")
   `RRD_ASSERT_IMPLY(a_no_underflow, pop, !head.empty, "result queue read while empty")

endmodule

// File: rtl/rrd_parser.sv
// Front end: accepts request bytes, tracks the framing state and forms
// the results of each byte. Holds the configuration registers.
// Depends on rrd_pkg and resp_request_deframer_defines.svh.
`include "resp_request_deframer_defines.svh"

module rrd_parser import rrd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic                   req_full,
   input  logic [7:0]             req_in_byte,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   q_push,
   output entry_type              q_entry
);

   typedef enum logic [8:0] {
      PH_PREFIX = 9'b000000001,
      PH_INLINE = 9'b000000010,
      PH_COUNT  = 9'b000000100,
      PH_DOLLAR = 9'b000001000,
      PH_LEN    = 9'b000010000,
      PH_DATA   = 9'b000100000,
      PH_CR     = 9'b001000000,
      PH_LF     = 9'b010000000,
      PH_HALT   = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic sign;
      logic minus;
      logic digits;
      logic cr;
      logic bad;
   } nflags_type;

   typedef struct packed {
      nflags_type       flags;
      logic [ACC_W-1:0] accum;
   } num_state_type;

   phase_type              phase_ff, phase_in;
   logic [ACC_W-1:0]       accum_ff, accum_in;
   nflags_type             nflags_ff, nflags_in;
   logic [LEN_W-1:0]       line_len_ff, line_len_in;
   logic [ARGS_W-1:0]      args_rem_ff, args_rem_in;
   logic [ACC_W-1:0]       bulk_rem_ff, bulk_rem_in;
   logic [ARG_IDX_W-1:0]   cur_arg_ff, cur_arg_in;
   logic                   open_ff, open_in;
   logic                   seen_ff, seen_in;
   logic [ARGS_W-1:0]      max_args_ff;
   logic [ACC_W-1:0]       max_bulk_ff;

   logic                   accept;
   logic                   has0, has1;
   result_type             res0, res1;

   // One character of a number line
   function automatic num_state_type num_char(num_state_type s, logic [7:0] c);
      logic               dig;
      logic [3:0]         d;
      logic [ACC_W+3:0]   prod;
      num_state_type      r;
      r    = s;
      dig  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      d    = c[3:0];
      prod = ({4'b0, s.accum} << 3) + ({4'b0, s.accum} << 1) + {{ACC_W{1'b0}}, d};
      if (!s.flags.bad) begin
         if (s.flags.digits) begin
            if (!dig) begin
               r.flags.bad = 1'b1;
            end else if (prod > {4'b0, ACC_MAX}) begin
               r.accum = ACC_MAX;
            end else begin
               r.accum = prod[ACC_W-1:0];
            end
         end else if (dig) begin
            r.flags.digits = 1'b1;
            r.accum        = {{(ACC_W-4){1'b0}}, d};
         end else if (s.flags.sign) begin
            r.flags.bad = 1'b1;
         end else if (c == CHAR_PLUS) begin
            r.flags.sign = 1'b1;
         end else if (c == CHAR_MINUS) begin
            r.flags.sign  = 1'b1;
            r.flags.minus = 1'b1;
         end else if (!is_space(c)) begin
            r.flags.bad = 1'b1;
         end
      end
      return r;
   endfunction

   assign accept = req_push && !req_full;

   always_comb begin
      num_state_type ns;
      logic          ok;
      logic          line_empty;
      logic          too_long;
      logic          is_lf;

      phase_in    = phase_ff;
      accum_in    = accum_ff;
      nflags_in   = nflags_ff;
      line_len_in = line_len_ff;
      args_rem_in = args_rem_ff;
      bulk_rem_in = bulk_rem_ff;
      cur_arg_in  = cur_arg_ff;
      open_in     = open_ff;
      seen_in     = seen_ff;
      has0        = 1'b0;
      has1        = 1'b0;
      res0        = '0;
      res1        = '0;
      ns.flags    = nflags_ff;
      ns.accum    = accum_ff;
      is_lf       = (req_in_byte == CHAR_LF);
      too_long    = (line_len_ff > LEN_W'(LINE_LIMIT));
      line_empty  = (line_len_ff == {{(LEN_W-1){1'b0}}, nflags_ff.cr});

      // Finished number line: valid and non-negative
      if (nflags_ff.bad) begin
         ok = 1'b0;
      end else if (!nflags_ff.digits) begin
         ok = line_empty;
      end else begin
         ok = !(nflags_ff.minus && (accum_ff != '0));
      end

      unique case (phase_ff) inside
         PH_PREFIX: begin
            cur_arg_in = '0;
            if (req_in_byte == CHAR_STAR) begin
               accum_in    = '0;
               nflags_in   = '0;
               line_len_in = '0;
               phase_in    = PH_COUNT;
            end else begin
               line_len_in = '0;
               phase_in    = PH_INLINE;
               open_in     = 1'b0;
               seen_in     = 1'b0;
               if (!is_space(req_in_byte)) begin
                  has0    = 1'b1;
                  res0    = mk_result(KIND_BYTE, req_in_byte, '0, CAUSE_NONE);
                  open_in = 1'b1;
                  seen_in = 1'b1;
               end
            end
         end
         PH_INLINE: begin
            if (is_lf) begin
               if (open_ff) begin
                  has0 = 1'b1;
                  res0 = mk_result(KIND_ARG_END, 8'h00, cur_arg_ff, CAUSE_NONE);
               end
               if (seen_ff) begin
                  if (open_ff) begin
                     has1 = 1'b1;
                     res1 = mk_result(KIND_CMD_END, 8'h00, '0, CAUSE_NONE);
                  end else begin
                     has0 = 1'b1;
                     res0 = mk_result(KIND_CMD_END, 8'h00, '0, CAUSE_NONE);
                  end
                  phase_in   = PH_PREFIX;
                  cur_arg_in = '0;
                  open_in    = 1'b0;
                  seen_in    = 1'b0;
               end else begin
                  has0     = 1'b1;
                  res0     = mk_result(KIND_STOP, 8'h00, '0, CAUSE_EMPTY_INLINE);
                  phase_in = PH_HALT;
               end
            end else if (too_long) begin
               has0     = 1'b1;
               res0     = mk_result(KIND_STOP, 8'h00, '0, CAUSE_LINE_LONG);
               phase_in = PH_HALT;
            end else begin
               line_len_in = line_len_ff + 1'b1;
               if (is_space(req_in_byte)) begin
                  if (open_ff) begin
                     has0    = 1'b1;
                     res0    = mk_result(KIND_ARG_END, 8'h00, cur_arg_ff, CAUSE_NONE);
                     open_in = 1'b0;
                     if (cur_arg_ff != ARG_IDX_MAX) begin
                        cur_arg_in = cur_arg_ff + 1'b1;
                     end
                  end
               end else begin
                  has0    = 1'b1;
                  res0    = mk_result(KIND_BYTE, req_in_byte, cur_arg_ff, CAUSE_NONE);
                  open_in = 1'b1;
                  seen_in = 1'b1;
               end
            end
         end
         PH_COUNT, PH_LEN: begin
            if (is_lf) begin
               if (phase_ff == PH_COUNT) begin
                  if (!ok || (accum_ff == '0) || (accum_ff > ACC_W'(max_args_ff))) begin
                     has0     = 1'b1;
                     res0     = mk_result(KIND_STOP, 8'h00, '0, CAUSE_BAD_COUNT);
                     phase_in = PH_HALT;
                  end else begin
                     args_rem_in = accum_ff[ARGS_W-1:0];
                     cur_arg_in  = '0;
                     phase_in    = PH_DOLLAR;
                  end
               end else if (!ok || (accum_ff > max_bulk_ff)) begin
                  has0     = 1'b1;
                  res0     = mk_result(KIND_STOP, 8'h00, '0, CAUSE_BAD_LENGTH);
                  phase_in = PH_HALT;
               end else begin
                  bulk_rem_in = accum_ff;
                  phase_in    = (accum_ff != '0) ? PH_DATA : PH_CR;
               end
            end else if (too_long) begin
               has0     = 1'b1;
               res0     = mk_result(KIND_STOP, 8'h00, '0, CAUSE_LINE_LONG);
               phase_in = PH_HALT;
            end else begin
               line_len_in = line_len_ff + 1'b1;
               // A held CR not followed by LF counts as whitespace
               if (ns.flags.cr) begin
                  ns.flags.cr = 1'b0;
                  ns = num_char(ns, CHAR_CR);
               end
               if (req_in_byte == CHAR_CR) begin
                  ns.flags.cr = 1'b1;
               end else begin
                  ns = num_char(ns, req_in_byte);
               end
               nflags_in = ns.flags;
               accum_in  = ns.accum;
            end
         end
         PH_DOLLAR: begin
            if (req_in_byte == CHAR_DOLLAR) begin
               accum_in    = '0;
               nflags_in   = '0;
               line_len_in = '0;
               phase_in    = PH_LEN;
            end else begin
               has0     = 1'b1;
               res0     = mk_result(KIND_STOP, 8'h00, '0, CAUSE_NO_DOLLAR);
               phase_in = PH_HALT;
            end
         end
         PH_DATA: begin
            has0        = 1'b1;
            res0        = mk_result(KIND_BYTE, req_in_byte, cur_arg_ff, CAUSE_NONE);
            bulk_rem_in = bulk_rem_ff - 1'b1;
            if (bulk_rem_in == '0) begin
               phase_in = PH_CR;
            end
         end
         PH_CR: begin
            if (req_in_byte == CHAR_CR) begin
               phase_in = PH_LF;
            end else begin
               has0     = 1'b1;
               res0     = mk_result(KIND_STOP, 8'h00, '0, CAUSE_NO_CRLF);
               phase_in = PH_HALT;
            end
         end
         PH_LF: begin
            if (is_lf) begin
               has0        = 1'b1;
               res0        = mk_result(KIND_ARG_END, 8'h00, cur_arg_ff, CAUSE_NONE);
               args_rem_in = args_rem_ff - 1'b1;
               if (args_rem_in == '0) begin
                  has1       = 1'b1;
                  res1       = mk_result(KIND_CMD_END, 8'h00, '0, CAUSE_NONE);
                  cur_arg_in = '0;
                  phase_in   = PH_PREFIX;
               end else begin
                  if (cur_arg_ff != ARG_IDX_MAX) begin
                     cur_arg_in = cur_arg_ff + 1'b1;
                  end
                  phase_in = PH_DOLLAR;
               end
            end else begin
               has0     = 1'b1;
               res0     = mk_result(KIND_STOP, 8'h00, '0, CAUSE_NO_CRLF);
               phase_in = PH_HALT;
            end
         end
         default: begin
            // halted: drop every byte
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_PREFIX;
         accum_ff    <= '0;
         nflags_ff   <= '0;
         line_len_ff <= '0;
         args_rem_ff <= '0;
         bulk_rem_ff <= '0;
         cur_arg_ff  <= '0;
         open_ff     <= 1'b0;
         seen_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         accum_ff    <= accum_in;
         nflags_ff   <= nflags_in;
         line_len_ff <= line_len_in;
         args_rem_ff <= args_rem_in;
         bulk_rem_ff <= bulk_rem_in;
         cur_arg_ff  <= cur_arg_in;
         open_ff     <= open_in;
         seen_ff     <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_args_ff <= MAX_ARGUMENTS_RESET;
         max_bulk_ff <= MAX_BULK_LENGTH_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_MAX_ARGUMENTS) begin
            max_args_ff <= csr_wdata[ARGS_W-1:0];
         end else if (csr_index == CSR_MAX_BULK_LENGTH) begin
            max_bulk_ff <= csr_wdata[ACC_W-1:0];
         end
      end
   end

   assign q_push        = accept && has0;
   assign q_entry.two   = has1;
   assign q_entry.r0    = res0;
   assign q_entry.r1    = res1;

   `RRD_ASSERT_NEXT(a_halt_sticky, phase_ff == PH_HALT, phase_ff == PH_HALT,
      "left halt without reset")
   `RRD_ASSERT_IMPLY(a_stop_alone, q_push && q_entry.two,
      (q_entry.r0.kind != KIND_STOP) && (q_entry.r1.kind != KIND_STOP),
      "stop paired with another result")
   `RRD_ASSERT_IMPLY(a_stop_halts, q_push && (q_entry.r0.kind == KIND_STOP),
      phase_in == PH_HALT, "stop issued without halting")

endmodule

// File: rtl/rrd_emitter.sv
// Back end: presents the queued results one at a time on the result port
// and marks the final result of each byte. Depends on rrd_pkg and
// resp_request_deframer_defines.svh.
`include "resp_request_deframer_defines.svh"

module rrd_emitter import rrd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  head_type             head,
   output logic                 deq,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [1:0]           rsp_kind,
   output logic [7:0]           rsp_value,
   output logic [ARG_IDX_W-1:0] rsp_arg_index,
   output logic [2:0]           rsp_stop_cause,
   output logic                 rsp_last
);

   logic       sel_ff, sel_in;
   logic       take;
   result_type cur;

   assign cur       = sel_ff ? head.entry.r1 : head.entry.r0;
   assign rsp_last  = !head.entry.two || sel_ff;
   assign rsp_empty = head.empty;
   assign take      = rsp_pop && !head.empty;
   assign deq       = take && rsp_last;

   // Advance to the second result, or release the entry after the last one
   always_comb begin
      sel_in = sel_ff;
      if (take) begin
         sel_in = !rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

   assign rsp_kind       = cur.kind;
   assign rsp_value      = cur.value;
   assign rsp_arg_index  = cur.arg_index;
   assign rsp_stop_cause = cur.cause;

   `RRD_ASSERT_NEXT(a_second_shown, take && !rsp_last, sel_ff && !head.empty, "second result of pair lost")
   `RRD_ASSERT_IMPLY(a_sel_pair, sel_ff, head.entry.two && !head.empty, "second slot selected on single entry")

endmodule

// File: rtl/resp_request_deframer.sv
// Request deframer top level: splits a request byte stream into argument
// items. Instantiates rrd_parser, rrd_queue and rrd_emitter; uses rrd_pkg.
// Usage
//   Input: one request byte per item on req_in_byte, taken at a clock edge
//   where req_push is high and req_full is low. Bytes of array commands
//   ('*' count line, then '$' length line, raw data and CR LF per argument)
//   and inline commands (whitespace-separated tokens ending at LF) are
//   turned into argument bytes, argument ends and command ends.
//   Output: the oldest result sits on rsp_* while rsp_empty is low and is
//   taken at an edge where rsp_pop is high; rsp_last marks the final result
//   of its input byte. A byte gives zero, one or two results.
//   Configuration: csr_valid writes csr_wdata to register csr_index
//   (0 max arguments, 1 max bulk length); csr_ready is always high.
//   Timing: one byte per cycle while req_full is low. Results of a byte are
//   queued when it is taken; a byte with two results needs two pops.
//   A framing error gives one session stop result, after which all bytes
//   are taken and dropped until reset.
//   Stall: a four-entry result queue absorbs a stalled receiver; when it
//   fills, req_full rises until an entry is released.
//   Reset: synchronous; clears framing state and queue, restores defaults.

module resp_request_deframer import rrd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_in_byte,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_value,
   output logic [ARG_IDX_W-1:0]   rsp_arg_index,
   output logic [2:0]             rsp_stop_cause,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic      q_push;
   entry_type q_entry;
   logic      q_full;
   logic      q_pop;
   head_type  q_head;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;

   rrd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (q_full),
      .req_in_byte (req_in_byte),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   rrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head)
   );

   rrd_emitter u_emitter (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .deq            (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_kind       (rsp_kind),
      .rsp_value      (rsp_value),
      .rsp_arg_index  (rsp_arg_index),
      .rsp_stop_cause (rsp_stop_cause),
      .rsp_last       (rsp_last)
   );

endmodule
